@@ rtl/cscan_pkg.sv @@
// Shared constants, word types and cell commands of the C-SCAN request scheduler.
package cscan_pkg;

    localparam int MAX_REQUESTS   = 32;
    localparam int TRACK_BITS     = 16;
    localparam int COUNT_BITS     = $clog2(MAX_REQUESTS + 1);
    localparam int IN_TRACK_BITS  = 16;
    localparam int HEAD_BITS      = 16;
    localparam int DISK_BITS      = 17;
    localparam int OUT_TRACK_BITS = 16;
    localparam int SEEK_BITS      = 18;
    localparam int CMP_BITS       = (TRACK_BITS > HEAD_BITS) ? TRACK_BITS : HEAD_BITS;
    localparam int SUM_BITS       = ((CMP_BITS > SEEK_BITS) ? CMP_BITS : SEEK_BITS) + 1;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEAD_START  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DISK_TRACKS = CFG_INDEX_BITS'(1);

    localparam logic [HEAD_BITS-1:0] HEAD_RESET = '0;
    localparam logic [DISK_BITS-1:0] DISK_RESET = DISK_BITS'(65536);
    localparam logic [DISK_BITS-1:0] LAST_LIMIT = (TRACK_BITS < OUT_TRACK_BITS) ?
                                                  DISK_BITS'((64'd1 << TRACK_BITS) - 64'd1) :
                                                  DISK_BITS'((64'd1 << OUT_TRACK_BITS) - 64'd1);
    localparam logic [SEEK_BITS-1:0] SEEK_MAX   = '1;

    typedef struct packed {
        logic [IN_TRACK_BITS-1:0] request_track;
        logic                     batch_end;
    } t_in_word;

    typedef struct packed {
        logic [OUT_TRACK_BITS-1:0] served_track;
        logic [SEEK_BITS-1:0]      seek_total;
        logic                      sequence_end;
    } t_out_word;

    typedef struct packed {
        logic                  valid;
        logic [TRACK_BITS-1:0] track;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [TRACK_BITS-1:0] key;
    } t_cell_cmd;

endpackage

@@ rtl/cscan_cell.sv @@
// One sorting cell: holds a track, inserts in order, shifts toward the head of the row.
module cscan_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cscan_pkg::t_cell_cmd i_cmd,
    input  cscan_pkg::t_entry    i_prev,
    input  cscan_pkg::t_entry    i_next,
    output cscan_pkg::t_entry    o_entry
);
    import cscan_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_keep;
    logic   w_take_prev;

    assign w_keep      = r_entry.valid && (r_entry.track <= i_cmd.key);
    assign w_take_prev = i_prev.valid && (i_prev.track > i_cmd.key);

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (w_keep) begin
                    n_entry = r_entry;
                end else if (w_take_prev) begin
                    n_entry = i_prev;
                end else begin
                    n_entry.valid = r_entry.valid | i_prev.valid;
                    n_entry.track = i_cmd.key;
                end
            end
            CELL_SHIFT: begin
                n_entry = i_next;
            end
            CELL_CLEAR: begin
                n_entry.valid = 1'b0;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.track <= n_entry.track;
    end

    assign o_entry = r_entry;

endmodule

@@ rtl/cscan_chain.sv @@
// Row of sorting cells kept in ascending order, read and refilled at its ends.
module cscan_chain (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cscan_pkg::t_cell_cmd i_cmd,
    input  cscan_pkg::t_entry    i_tail,
    output cscan_pkg::t_entry    o_head
);
    import cscan_pkg::*;

    t_entry w_entry [MAX_REQUESTS];
    t_entry w_prev  [MAX_REQUESTS];
    t_entry w_next  [MAX_REQUESTS];

    genvar g;
    generate
        for (g = 0; g < MAX_REQUESTS; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_prev[g] = '{valid: 1'b1, track: '0};
            end else begin : g_inner
                assign w_prev[g] = w_entry[g-1];
            end
            if (g == MAX_REQUESTS - 1) begin : g_last
                assign w_next[g] = i_tail;
            end else begin : g_body
                assign w_next[g] = w_entry[g+1];
            end
            cscan_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (i_cmd),
                .i_prev  (w_prev[g]),
                .i_next  (w_next[g]),
                .o_entry (w_entry[g])
            );
        end
    endgenerate

    assign o_head = w_entry[0];

endmodule

@@ rtl/cscan_disk_request_scheduler_unit.sv @@
// C-SCAN request scheduler top level: batch loading, sweep sequencing and output word.
//
// Requests load one per cycle into a 32-cell sorted row; each cell compares
// the new track against its own and takes its neighbor's track when it must
// make room. Requests beyond the 32nd of a batch are dropped, but a batch end
// on such a request still closes the batch. After the closing word the block
// rotates every request below the head position to the far end of the row,
// one per cycle, and drops requests at the head position. It then emits the
// upper sweep with the last track merged in, one word per cycle, switches
// sweeps, emits track 0, and emits the lower sweep, walking past emptied
// cells. Every output step waits while a previous word is still held unread;
// head_start and disk_tracks are sampled when the batch closes. A new batch
// is accepted once the last word of the previous one has been placed in the
// output register.
module cscan_disk_request_scheduler_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  cscan_pkg::t_in_word                   i_in_word,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output cscan_pkg::t_out_word                  o_out_word,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [cscan_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [cscan_pkg::DISK_BITS-1:0]       i_cfg_data
);
    import cscan_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_SKIP = 5'b00010,
        S_HI   = 5'b00100,
        S_ZERO = 5'b01000,
        S_LO   = 5'b10000
    } t_state;

    t_state                r_state,       n_state;
    logic [HEAD_BITS-1:0]  r_head;
    logic [DISK_BITS-1:0]  r_disk_tracks;
    logic [COUNT_BITS-1:0] r_count,       n_count;
    logic [COUNT_BITS-1:0] r_lo_cnt,      n_lo_cnt;
    logic [CMP_BITS-1:0]   r_base,        n_base;
    logic [TRACK_BITS-1:0] r_last,        n_last;
    logic                  r_last_pend,   n_last_pend;
    logic [CMP_BITS-1:0]   r_pos,         n_pos;
    logic [SEEK_BITS-1:0]  r_total,       n_total;
    logic                  r_out_valid,   n_out_valid;
    t_out_word             r_out,         n_out;

    t_cell_cmd             w_cmd;
    t_entry                w_tail;
    t_entry                w_head;
    logic                  w_in_acc;
    logic                  w_store;
    logic                  w_close;
    logic                  w_can_emit;
    logic                  w_head_le;
    logic                  w_head_lt;
    logic                  w_take_head;
    logic [CMP_BITS-1:0]   w_head_cmp;
    logic [CMP_BITS-1:0]   w_cand;
    logic [CMP_BITS-1:0]   w_dist;
    logic [CMP_BITS-1:0]   w_step;
    logic [SUM_BITS-1:0]   w_sum;
    logic [SEEK_BITS-1:0]  w_total_next;
    logic [DISK_BITS-1:0]  w_dtm1;
    logic [DISK_BITS-1:0]  w_last;

    cscan_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_tail  (w_tail),
        .o_head  (w_head)
    );

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_store     = w_in_acc && (r_count < COUNT_BITS'(MAX_REQUESTS));
    assign w_close     = w_in_acc && i_in_word.batch_end;
    assign w_can_emit  = !r_out_valid || i_out_ready;

    assign w_head_cmp  = CMP_BITS'(w_head.track);
    assign w_head_le   = w_head.valid && (w_head_cmp <= r_base);
    assign w_head_lt   = w_head_cmp < r_base;
    assign w_take_head = (r_count != '0) && (!r_last_pend || (w_head.track < r_last));

    assign w_dtm1 = (r_disk_tracks == '0) ? '0 : (r_disk_tracks - DISK_BITS'(1));
    assign w_last = (w_dtm1 > LAST_LIMIT) ? LAST_LIMIT : w_dtm1;

    assign w_cand = ((r_state == S_HI) && !w_take_head) ? CMP_BITS'(r_last) : w_head_cmp;
    assign w_dist = (w_cand >= r_pos) ? (w_cand - r_pos) : (r_pos - w_cand);
    assign w_step = (r_state == S_ZERO) ? CMP_BITS'(r_last) : w_dist;
    assign w_sum  = SUM_BITS'(r_total) + SUM_BITS'(w_step);
    assign w_total_next = (w_sum > SUM_BITS'(SEEK_MAX)) ? SEEK_MAX : SEEK_BITS'(w_sum);

    assign w_tail = '{valid: (r_state == S_SKIP) && w_head_lt, track: w_head.track};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo_cnt    = r_lo_cnt;
        n_base      = r_base;
        n_last      = r_last;
        n_last_pend = r_last_pend;
        n_pos       = r_pos;
        n_total     = r_total;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_cmd.op    = CELL_HOLD;
        w_cmd.key   = TRACK_BITS'(i_in_word.request_track);
        case (r_state)
            S_LOAD: begin
                if (w_store) begin
                    w_cmd.op = CELL_INSERT;
                    n_count  = r_count + COUNT_BITS'(1);
                end
                if (w_close) begin
                    n_base      = CMP_BITS'(r_head);
                    n_last      = TRACK_BITS'(w_last);
                    n_last_pend = 1'b1;
                    n_lo_cnt    = '0;
                    n_pos       = CMP_BITS'(r_head);
                    n_total     = '0;
                    n_state     = S_SKIP;
                end
            end
            S_SKIP: begin
                if ((r_count != '0) && w_head_le) begin
                    w_cmd.op = CELL_SHIFT;
                    n_count  = r_count - COUNT_BITS'(1);
                    if (w_head_lt) begin
                        n_lo_cnt = r_lo_cnt + COUNT_BITS'(1);
                    end
                end else begin
                    n_state = S_HI;
                end
            end
            S_HI: begin
                if (w_take_head || r_last_pend) begin
                    if (w_can_emit) begin
                        n_out_valid        = 1'b1;
                        n_out.served_track = OUT_TRACK_BITS'(w_cand);
                        n_out.seek_total   = w_total_next;
                        n_out.sequence_end = 1'b0;
                        n_total            = w_total_next;
                        n_pos              = w_cand;
                        if (w_take_head) begin
                            w_cmd.op = CELL_SHIFT;
                            n_count  = r_count - COUNT_BITS'(1);
                        end else begin
                            n_last_pend = 1'b0;
                        end
                    end
                end else begin
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                if (w_can_emit) begin
                    n_out_valid        = 1'b1;
                    n_out.served_track = '0;
                    n_out.seek_total   = w_total_next;
                    n_out.sequence_end = (r_lo_cnt == '0);
                    n_total            = w_total_next;
                    n_pos              = '0;
                    n_state            = (r_lo_cnt == '0) ? S_LOAD : S_LO;
                end
            end
            S_LO: begin
                if (!w_head.valid) begin
                    w_cmd.op = CELL_SHIFT;
                end else if (w_can_emit) begin
                    w_cmd.op           = CELL_SHIFT;
                    n_out_valid        = 1'b1;
                    n_out.served_track = OUT_TRACK_BITS'(w_cand);
                    n_out.seek_total   = w_total_next;
                    n_out.sequence_end = (r_lo_cnt == COUNT_BITS'(1));
                    n_total            = w_total_next;
                    n_pos              = w_cand;
                    n_lo_cnt           = r_lo_cnt - COUNT_BITS'(1);
                    if (r_lo_cnt == COUNT_BITS'(1)) begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                w_cmd.op = CELL_CLEAR;
                n_count  = '0;
                n_state  = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_LOAD;
            r_head        <= HEAD_RESET;
            r_disk_tracks <= DISK_RESET;
            r_count       <= '0;
            r_lo_cnt      <= '0;
            r_last_pend   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_lo_cnt    <= n_lo_cnt;
            r_last_pend <= n_last_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_HEAD_START) begin
                    r_head <= HEAD_BITS'(i_cfg_data);
                end else if (i_cfg_index == CFG_DISK_TRACKS) begin
                    r_disk_tracks <= i_cfg_data;
                end
            end
        end
        r_base  <= n_base;
        r_last  <= n_last;
        r_pos   <= n_pos;
        r_total <= n_total;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef NO_ASSERTIONS
    a_close_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_close |=> (r_state == S_SKIP) && r_last_pend)
        else $error("batch close did not start the sweep");
    a_zero_after_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ZERO) |-> (!r_last_pend && (r_count == '0)))
        else $error("track 0 reached with upper sweep unfinished");
    a_lower_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LO) |-> (r_lo_cnt != '0))
        else $error("lower sweep entered with nothing to serve");
    a_end_returns_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid && r_out.sequence_end) |-> (r_state == S_LOAD))
        else $error("final word issued while sweep still active");
`endif

endmodule

@@ verif/cscan_disk_request_scheduler_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the C-SCAN request scheduler: directed and random batches.
module cscan_disk_request_scheduler_unit_tb;
    import cscan_pkg::*;

    localparam int          SETTLE_CYCLES = 80;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          RANDOM_ITEMS  = 290;
    localparam int unsigned SEEK_CEILING  = 262143;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    t_in_word                  i_in_word = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    t_out_word                 o_out_word;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = CFG_HEAD_START;
    logic [DISK_BITS-1:0]      i_cfg_data = '0;

    cscan_disk_request_scheduler_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    logic [HEAD_BITS-1:0]     head_cfg = HEAD_RESET;
    logic [DISK_BITS-1:0]     disk_cfg = DISK_RESET;
    logic [TRACK_BITS-1:0]    batch_tracks [0:MAX_REQUESTS-1];
    int                       batch_count = 0;
    t_out_word                pending_visits [$];
    t_out_word                visit_exp;
    logic [TRACK_BITS-1:0]    recent_track = '0;
    int                       mismatch_count = 0;
    int                       cycle_count = 0;
    int                       random_items = 0;
    int                       stall_mode = 0;
    int                       gap_max = 0;
    int                       burst_left = 0;
    int                       rx_tick = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        case (stall_mode)
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            2: i_out_ready <= ((rx_tick % 8) < 5);
            3: i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_visits.size() == 0) begin
                $error("unexpected word: track %0d, seek %0d", o_out_word.served_track,
                       o_out_word.seek_total);
                mismatch_count++;
            end else begin
                visit_exp = pending_visits.pop_front();
                if (o_out_word.served_track !== visit_exp.served_track) begin
                    $error("served_track: expected %0d, got %0d", visit_exp.served_track,
                           o_out_word.served_track);
                    mismatch_count++;
                end
                if (o_out_word.seek_total !== visit_exp.seek_total) begin
                    $error("seek_total: expected %0d, got %0d", visit_exp.seek_total,
                           o_out_word.seek_total);
                    mismatch_count++;
                end
                if (o_out_word.sequence_end !== visit_exp.sequence_end) begin
                    $error("sequence_end: expected %0d, got %0d", visit_exp.sequence_end,
                           o_out_word.sequence_end);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic int unsigned add_seek(input int unsigned total, input int unsigned step);
        int unsigned sum;
        sum = total + step;
        return (sum > SEEK_CEILING) ? SEEK_CEILING : sum;
    endfunction

    function automatic int unsigned track_gap(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic schedule_sweep();
        int unsigned up [0:MAX_REQUESTS];
        int unsigned down [0:MAX_REQUESTS];
        int          nu;
        int          nd;
        int          i;
        int          j;
        int unsigned v;
        int unsigned last_trk;
        int unsigned pos;
        int unsigned total;
        t_out_word   w;
        last_trk = ((disk_cfg == 0) ? 1 : int'(disk_cfg)) - 1;
        if (last_trk > int'(LAST_LIMIT)) last_trk = LAST_LIMIT;
        up[0] = last_trk;
        nu = 1;
        down[0] = 0;
        nd = 1;
        for (i = 0; i < batch_count; i++) begin
            v = batch_tracks[i];
            if (v > head_cfg) begin
                j = nu;
                while (j > 0 && up[j-1] > v) begin
                    up[j] = up[j-1];
                    j--;
                end
                up[j] = v;
                nu++;
            end else if (v < head_cfg) begin
                j = nd;
                while (j > 0 && down[j-1] > v) begin
                    down[j] = down[j-1];
                    j--;
                end
                down[j] = v;
                nd++;
            end
        end
        pos = head_cfg;
        total = 0;
        for (i = 0; i < nu; i++) begin
            total = add_seek(total, track_gap(up[i], pos));
            pos = up[i];
            w.served_track = OUT_TRACK_BITS'(up[i]);
            w.seek_total = SEEK_BITS'(total);
            w.sequence_end = 1'b0;
            pending_visits = {pending_visits, w};
        end
        total = add_seek(total, last_trk);
        pos = 0;
        for (i = 0; i < nd; i++) begin
            total = add_seek(total, track_gap(down[i], pos));
            pos = down[i];
            w.served_track = OUT_TRACK_BITS'(down[i]);
            w.seek_total = SEEK_BITS'(total);
            w.sequence_end = (i == nd - 1);
            pending_visits = {pending_visits, w};
        end
        batch_count = 0;
    endtask

    task automatic send_word(input logic [TRACK_BITS-1:0] trk, input logic last);
        t_in_word w;
        w.request_track = trk;
        w.batch_end = last;
        if (gap_max != 0 && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (burst_left > 0) burst_left--;
        recent_track = trk;
        if (batch_count < MAX_REQUESTS) begin
            batch_tracks[batch_count] = trk;
            batch_count++;
        end
        if (last) schedule_sweep();
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_visits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [DISK_BITS-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HEAD_START) head_cfg = data[HEAD_BITS-1:0];
        else if (idx == CFG_DISK_TRACKS) disk_cfg = data;
    endtask

    function automatic logic [TRACK_BITS-1:0] pick_track();
        case ($urandom_range(0, 7))
            0: return head_cfg;
            1: return head_cfg + TRACK_BITS'($urandom_range(1, 20));
            2: return head_cfg - TRACK_BITS'($urandom_range(1, 20));
            3: return recent_track;
            4: return TRACK_BITS'(disk_cfg + $urandom_range(0, 40) - 20);
            5: return $urandom_range(0, 1) ? '0 : '1;
            default: return TRACK_BITS'($urandom);
        endcase
    endfunction

    task automatic run_batch(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            send_word(pick_track(), k == n - 1);
            random_items++;
        end
    endtask

    task automatic test_reset_config();
        send_word(16'd0, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'd100, 1'b0);
        send_word(16'd100, 1'b0);
        send_word(16'd7, 1'b1);
        send_word(16'h5555, 1'b1);
    endtask

    task automatic test_head_in_middle();
        stall_mode = 1;
        gap_max = 3;
        write_reg(CFG_HEAD_START, 17'h19C40);
        write_reg(CFG_DISK_TRACKS, 17'd50000);
        send_word(16'd40000, 1'b0);
        send_word(16'd60000, 1'b0);
        send_word(16'd39999, 1'b0);
        send_word(16'd40001, 1'b0);
        send_word(16'd0, 1'b0);
        send_word(16'd49999, 1'b0);
        send_word(16'hAAAA, 1'b0);
        send_word(16'd1, 1'b1);
    endtask

    task automatic test_disk_extremes();
        stall_mode = 2;
        gap_max = 0;
        write_reg(CFG_DISK_TRACKS, 17'd0);
        write_reg(CFG_HEAD_START, 17'h1FFFF);
        send_word(16'hFFFF, 1'b1);
        send_word(16'd3, 1'b1);
        write_reg(CFG_DISK_TRACKS, 17'd1);
        write_reg(CFG_HEAD_START, 17'd0);
        send_word(16'd0, 1'b1);
        write_reg(CFG_DISK_TRACKS, 17'h1FFFF);
        write_reg(CFG_HEAD_START, 17'd32768);
        send_word(16'd32768, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'd12345, 1'b1);
    endtask

    task automatic test_store_full();
        int k;
        stall_mode = 3;
        gap_max = 4;
        write_reg(CFG_HEAD_START, 17'd1000);
        write_reg(CFG_DISK_TRACKS, 17'd65536);
        for (k = 0; k < MAX_REQUESTS + 2; k++) send_word(pick_track(), k == MAX_REQUESTS + 1);
        for (k = 0; k < MAX_REQUESTS; k++) send_word(pick_track(), k == MAX_REQUESTS - 1);
    endtask

    task automatic test_random_traffic();
        logic [HEAD_BITS-1:0] h;
        logic [DISK_BITS-1:0] d;
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0: h = '0;
                    1: h = '1;
                    default: h = HEAD_BITS'($urandom);
                endcase
                write_reg(CFG_HEAD_START, {1'($urandom), h});
                case ($urandom_range(0, 6))
                    0: d = '0;
                    1: d = 17'd1;
                    2: d = DISK_RESET;
                    3: d = '1;
                    4: d = DISK_BITS'(h + $urandom_range(1, 1000));
                    default: d = DISK_BITS'($urandom);
                endcase
                write_reg(CFG_DISK_TRACKS, d);
            end
            stall_mode = $urandom_range(0, 3);
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat ($urandom_range(1, 4)) begin
                run_batch(($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) :
                                                        $urandom_range(1, 10));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_config();
        test_head_in_middle();
        test_disk_extremes();
        test_store_full();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
